/* rtl/gfi_pkg.sv */
`default_nettype none

package gfi_pkg;

   // Widths of the fixed fields at the ports.
   localparam int INDEX_W     = 8;
   localparam int FRAC_IN_W   = 16;
   localparam int SAMPLE_IN_W = 24;
   localparam int OUT_W       = 26;
   localparam int SIZE_W      = 6;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 6;

   // Transaction kinds on the request channel.
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = 2'd3;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

   // Neighbourhood walk: points per axis minus one, and MAC steps minus one.
   localparam int           NBUF        = 4;
   localparam logic [1:0]   LAST_LIN    = 2'd1;
   localparam logic [1:0]   LAST_CUB    = 2'd3;
   localparam logic [1:0]   STEP_LIN    = 2'd0;
   localparam logic [1:0]   STEP_CUB    = 2'd2;
   localparam logic [1:0]   LVL_TOP     = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_PREP,
      ST_MAC,
      ST_STORE
   } state_type;

   // Clamp cell index plus neighbour offset to [0, eff-1]. Cubic offsets run -1..2.
   function automatic logic [SIZE_W-1:0] clamp_coord(
      input logic signed [INDEX_W-1:0] idx,
      input logic [1:0]                cnt,
      input logic                      cubic,
      input logic [SIZE_W-1:0]         eff
   );
      logic signed [9:0] pos;
      logic signed [9:0] top;
      pos = 10'(idx) + signed'(10'(cnt)) - signed'(10'(cubic));
      top = signed'(10'(eff)) - 10'sd1;
      if (pos < 10'sd0) begin
         return '0;
      end else if (pos > top) begin
         return top[SIZE_W-1:0];
      end
      return pos[SIZE_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/gfi_grid_ram.sv */
`default_nettype none

module gfi_grid_ram #(
   parameter int DEPTH = 32768,
   parameter int AW    = 15,
   parameter int DW    = 24
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] addr,
   input  wire logic [DW-1:0] wdata,
   output logic      [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* rtl/gfi_mac.sv */
`default_nettype none

// q = a + round(t * b / 2^sh), sh = FW or FW+1, ties towards +infinity.
module gfi_mac #(
   parameter int VW = 32,
   parameter int FW = 16
) (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic signed [VW-1:0] a,
   input  wire logic signed [VW-1:0] b,
   input  wire logic        [FW-1:0] t,
   input  wire logic                 half,
   output logic      signed [VW-1:0] q
);

   localparam int PW = VW + FW + 1;

   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] bias;
   logic signed [PW-1:0] biased;
   logic signed [PW-1:0] shifted;
   logic signed [VW-1:0] q_in;
   logic signed [VW-1:0] q_ff;

   always_comb begin
      prod    = PW'(b) * signed'(PW'(t));
      bias    = half ? (PW'(1) <<< FW) : (PW'(1) <<< (FW - 1));
      biased  = prod + bias;
      shifted = half ? (biased >>> (FW + 1)) : (biased >>> FW);
      q_in    = a + VW'(shifted);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

`default_nettype wire

/* rtl/grid_field_interpolator.sv */
// Writes are accepted one per cycle while idle and may follow one another back to back.
// A query is worked through in groups: each group of 2 or 4 samples (linear or cubic)
// passes through its memory reads, prep, MAC steps and a store, one after another.
// The one memory port and the single multiply-round-add unit serialise this work.
// The block takes no new transaction until a query is reduced to its result.
// Reset (synchronous, active high) sets control and configuration; payload and grid keep no reset.
`default_nettype none

module grid_field_interpolator #(
   parameter int DIM_MAX     = 32,
   parameter int SAMPLE_BITS = 24,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic                                   req_action,
   input  wire logic signed [gfi_pkg::INDEX_W-1:0]     req_index_x,
   input  wire logic signed [gfi_pkg::INDEX_W-1:0]     req_index_y,
   input  wire logic signed [gfi_pkg::INDEX_W-1:0]     req_index_z,
   input  wire logic        [gfi_pkg::FRAC_IN_W-1:0]   req_frac_x,
   input  wire logic        [gfi_pkg::FRAC_IN_W-1:0]   req_frac_y,
   input  wire logic        [gfi_pkg::FRAC_IN_W-1:0]   req_frac_z,
   input  wire logic signed [gfi_pkg::SAMPLE_IN_W-1:0] req_sample_in,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic      signed [gfi_pkg::OUT_W-1:0]       rsp_field_value,
   output logic                                        rsp_saturated,
   input  wire logic                                   csr_we,
   input  wire logic        [gfi_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic        [gfi_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import gfi_pkg::*;

   // Intermediate values carry eight guard bits above the sample width; the
   // Catmull-Rom differences grow by at most a factor of about twenty.
   localparam int VW    = SAMPLE_BITS + 8;
   localparam int DEPTH = DIM_MAX ** 3;
   localparam int AW    = $clog2(DEPTH);
   localparam int CMPW  = ((VW > OUT_W) ? VW : OUT_W) + 1;

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic              mode_ff;
   logic [SIZE_W-1:0] size_x_ff;
   logic [SIZE_W-1:0] size_y_ff;
   logic [SIZE_W-1:0] size_z_ff;
   logic [SIZE_W-1:0] eff_x;
   logic [SIZE_W-1:0] eff_y;
   logic [SIZE_W-1:0] eff_z;

   // A size of zero behaves as one, a size above the grid as the grid.
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
      if (s == '0) begin
         return SIZE_W'(1);
      end else if (32'(s) > DIM_MAX) begin
         return SIZE_W'(DIM_MAX);
      end
      return s;
   endfunction

   assign eff_x = eff_size(size_x_ff);
   assign eff_y = eff_size(size_y_ff);
   assign eff_z = eff_size(size_z_ff);

   // ------------------------------------------------------------------
   // Sequencer state and working registers.
   // ------------------------------------------------------------------
   state_type state_ff, state_in;

   logic [1:0] cnt0_ff, cnt0_in;   // sample within the innermost group
   logic [1:0] cnt1_ff, cnt1_in;   // group within the middle level
   logic [1:0] cnt2_ff, cnt2_in;   // row within the outer level
   logic [1:0] step_ff, step_in;   // MAC step of the current 1-D reduction
   logic [1:0] lvl_ff,  lvl_in;    // which buffer is being reduced
   logic       cap_en_ff, cap_en_in;
   logic [1:0] cap_idx_ff, cap_idx_in;

   logic signed [INDEX_W-1:0] idx_x_ff, idx_x_in;
   logic signed [INDEX_W-1:0] idx_y_ff, idx_y_in;
   logic signed [INDEX_W-1:0] idx_z_ff, idx_z_in;
   logic [FRAC_BITS-1:0]      t_x_ff, t_x_in;
   logic [FRAC_BITS-1:0]      t_y_ff, t_y_in;
   logic [FRAC_BITS-1:0]      t_z_ff, t_z_in;

   logic signed [VW-1:0] buf0_ff [NBUF];
   logic signed [VW-1:0] buf0_in [NBUF];
   logic signed [VW-1:0] buf1_ff [NBUF];
   logic signed [VW-1:0] buf1_in [NBUF];
   logic signed [VW-1:0] buf2_ff [NBUF];
   logic signed [VW-1:0] buf2_in [NBUF];

   logic signed [VW-1:0] d1_ff, d1_in;
   logic signed [VW-1:0] d2_ff, d2_in;
   logic signed [VW-1:0] d3_ff, d3_in;
   logic signed [VW-1:0] base_ff, base_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                     rsp_sat_ff, rsp_sat_in;

   // ------------------------------------------------------------------
   // Frac and sample fields trimmed or zero-padded to the parameter widths.
   // ------------------------------------------------------------------
   logic [FRAC_IN_W+FRAC_BITS-1:0]     fx_ext;
   logic [FRAC_IN_W+FRAC_BITS-1:0]     fy_ext;
   logic [FRAC_IN_W+FRAC_BITS-1:0]     fz_ext;
   logic [SAMPLE_IN_W+SAMPLE_BITS-1:0] samp_ext;

   assign fx_ext   = {{FRAC_BITS{1'b0}}, req_frac_x};
   assign fy_ext   = {{FRAC_BITS{1'b0}}, req_frac_y};
   assign fz_ext   = {{FRAC_BITS{1'b0}}, req_frac_z};
   assign samp_ext = {{SAMPLE_BITS{1'b0}}, req_sample_in};

   // ------------------------------------------------------------------
   // Address generation. Linear mode walks x innermost, then y, then z;
   // cubic mode walks z innermost, then y, then x, with offsets -1..2.
   // ------------------------------------------------------------------
   logic              req_fire;
   logic [1:0]        last_cnt;
   logic [1:0]        last_step;
   logic [1:0]        ax_cnt_x;
   logic [1:0]        ax_cnt_z;
   logic [SIZE_W-1:0] rd_cx, rd_cy, rd_cz;
   logic [SIZE_W-1:0] wr_cx, wr_cy, wr_cz;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     wr_addr;

   assign req_fire  = req_valid && req_ready;
   assign last_cnt  = mode_ff ? LAST_CUB : LAST_LIN;
   assign last_step = mode_ff ? STEP_CUB : STEP_LIN;
   assign ax_cnt_x  = mode_ff ? cnt2_ff : cnt0_ff;
   assign ax_cnt_z  = mode_ff ? cnt0_ff : cnt2_ff;

   assign rd_cx = clamp_coord(idx_x_ff, ax_cnt_x, mode_ff, eff_x);
   assign rd_cy = clamp_coord(idx_y_ff, cnt1_ff, mode_ff, eff_y);
   assign rd_cz = clamp_coord(idx_z_ff, ax_cnt_z, mode_ff, eff_z);
   assign wr_cx = clamp_coord(req_index_x, 2'd0, 1'b0, eff_x);
   assign wr_cy = clamp_coord(req_index_y, 2'd0, 1'b0, eff_y);
   assign wr_cz = clamp_coord(req_index_z, 2'd0, 1'b0, eff_z);

   assign rd_addr = AW'((32'(rd_cx) * DIM_MAX + 32'(rd_cy)) * DIM_MAX + 32'(rd_cz));
   assign wr_addr = AW'((32'(wr_cx) * DIM_MAX + 32'(wr_cy)) * DIM_MAX + 32'(wr_cz));

   // ------------------------------------------------------------------
   // Grid memory and the shared multiply-round-add unit.
   // ------------------------------------------------------------------
   logic                   ram_we;
   logic [AW-1:0]          ram_addr;
   logic [SAMPLE_BITS-1:0] ram_rdata;
   logic signed [VW-1:0]   rd_sample;

   gfi_grid_ram #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (SAMPLE_BITS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (samp_ext[SAMPLE_BITS-1:0]),
      .rdata (ram_rdata)
   );

   assign rd_sample = VW'(signed'(ram_rdata));

   logic                 mac_en;
   logic signed [VW-1:0] mac_a;
   logic signed [VW-1:0] mac_b;
   logic [FRAC_BITS-1:0] mac_t;
   logic                 mac_half;
   logic signed [VW-1:0] mac_q;

   gfi_mac #(
      .VW (VW),
      .FW (FRAC_BITS)
   ) u_mac (
      .clock (clock),
      .en    (mac_en),
      .a     (mac_a),
      .b     (mac_b),
      .t     (mac_t),
      .half  (mac_half),
      .q     (mac_q)
   );

   // The counter of the level that receives the result of the current reduction.
   logic [1:0] up_cnt;
   logic       out_free;

   assign up_cnt   = (lvl_ff == 2'd0) ? cnt1_ff : cnt2_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // ------------------------------------------------------------------
   // Next state.
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_action == ACT_QUERY)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (cnt0_ff == last_cnt) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = ST_MAC;
         end
         ST_MAC: begin
            if (step_ff == last_step) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            if (lvl_ff == LVL_TOP) begin
               if (out_free) begin
                  state_in = ST_IDLE;
               end
            end else if (up_cnt == last_cnt) begin
               state_in = ST_PREP;
            end else begin
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer outputs: handshake, memory port and MAC operands.
   // ------------------------------------------------------------------
   always_comb begin
      req_ready = 1'b0;
      ram_we    = 1'b0;
      ram_addr  = rd_addr;
      mac_en    = 1'b0;
      mac_a     = base_ff;
      mac_b     = d1_ff;
      mac_half  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ram_we    = req_valid && (req_action == ACT_WRITE);
            ram_addr  = wr_addr;
         end
         ST_MAC: begin
            mac_en = 1'b1;
            if (mode_ff) begin
               // Horner form of the Catmull-Rom polynomial over three steps.
               case (step_ff)
                  2'd0: begin
                     mac_a = d2_ff;
                     mac_b = d3_ff;
                  end
                  2'd1: begin
                     mac_a = d1_ff;
                     mac_b = mac_q;
                  end
                  default: begin
                     mac_a    = base_ff;
                     mac_b    = mac_q;
                     mac_half = 1'b1;
                  end
               endcase
            end
         end
         ST_READ, ST_DRAIN, ST_PREP, ST_STORE: begin
         end
         default: begin
         end
      endcase
   end

   // Offset for the axis reduced at the current level.
   always_comb begin
      case (lvl_ff)
         2'd0:    mac_t = mode_ff ? t_z_ff : t_x_ff;
         2'd1:    mac_t = t_y_ff;
         default: mac_t = mode_ff ? t_x_ff : t_z_ff;
      endcase
   end

   // ------------------------------------------------------------------
   // Working register updates.
   // ------------------------------------------------------------------
   logic signed [VW-1:0]   v [NBUF];
   logic signed [CMPW-1:0] final_ext;

   always_comb begin
      case (lvl_ff)
         2'd0:    v = buf0_ff;
         2'd1:    v = buf1_ff;
         default: v = buf2_ff;
      endcase
   end

   assign final_ext = CMPW'(mac_q);

   always_comb begin
      cnt0_in      = cnt0_ff;
      cnt1_in      = cnt1_ff;
      cnt2_in      = cnt2_ff;
      step_in      = step_ff;
      lvl_in       = lvl_ff;
      idx_x_in     = idx_x_ff;
      idx_y_in     = idx_y_ff;
      idx_z_in     = idx_z_ff;
      t_x_in       = t_x_ff;
      t_y_in       = t_y_ff;
      t_z_in       = t_z_ff;
      buf0_in      = buf0_ff;
      buf1_in      = buf1_ff;
      buf2_in      = buf2_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      d3_in        = d3_ff;
      base_in      = base_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      cap_en_in    = (state_ff == ST_READ);
      cap_idx_in   = cnt0_ff;

      // Memory read data lands in the cycle after its address was issued.
      if (cap_en_ff) begin
         buf0_in[cap_idx_ff] = rd_sample;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_action == ACT_QUERY)) begin
               idx_x_in = req_index_x;
               idx_y_in = req_index_y;
               idx_z_in = req_index_z;
               t_x_in   = fx_ext[FRAC_BITS-1:0];
               t_y_in   = fy_ext[FRAC_BITS-1:0];
               t_z_in   = fz_ext[FRAC_BITS-1:0];
               cnt0_in  = '0;
               cnt1_in  = '0;
               cnt2_in  = '0;
               lvl_in   = '0;
            end
         end
         ST_READ: begin
            cnt0_in = (cnt0_ff == last_cnt) ? 2'd0 : cnt0_ff + 2'd1;
         end
         ST_PREP: begin
            step_in = '0;
            if (mode_ff) begin
               base_in = v[1];
               d1_in   = v[2] - v[0];
               d3_in   = (v[3] - v[0]) + 3 * (v[1] - v[2]);
               d2_in   = 2 * v[0] - 5 * v[1] + 4 * v[2] - v[3];
            end else begin
               base_in = v[0];
               d1_in   = v[1] - v[0];
            end
         end
         ST_MAC: begin
            step_in = step_ff + 2'd1;
         end
         ST_STORE: begin
            if (lvl_ff == LVL_TOP) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = final_ext[OUT_W-1:0];
                  rsp_sat_in   = 1'b0;
                  if (final_ext > CMPW'((64'sd1 <<< (OUT_W - 1)) - 64'sd1)) begin
                     rsp_value_in = {1'b0, {(OUT_W - 1){1'b1}}};
                     rsp_sat_in   = 1'b1;
                  end else if (final_ext < -CMPW'(64'sd1 <<< (OUT_W - 1))) begin
                     rsp_value_in = {1'b1, {(OUT_W - 1){1'b0}}};
                     rsp_sat_in   = 1'b1;
                  end
               end
            end else begin
               if (lvl_ff == 2'd0) begin
                  buf1_in[cnt1_ff] = mac_q;
               end else begin
                  buf2_in[cnt2_ff] = mac_q;
               end
               if (up_cnt == last_cnt) begin
                  lvl_in = lvl_ff + 2'd1;
               end else begin
                  if (lvl_ff == 2'd0) begin
                     cnt1_in = cnt1_ff + 2'd1;
                  end else begin
                     cnt2_in = cnt2_ff + 2'd1;
                     cnt1_in = '0;
                  end
                  lvl_in = '0;
               end
            end
         end
         ST_DRAIN: begin
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
         size_x_ff    <= SIZE_RESET;
         size_y_ff    <= SIZE_RESET;
         size_z_ff    <= SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         cap_en_ff    <= cap_en_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_MODE:   mode_ff   <= csr_wdata[0];
               CSR_SIZE_X: size_x_ff <= csr_wdata;
               CSR_SIZE_Y: size_y_ff <= csr_wdata;
               CSR_SIZE_Z: size_z_ff <= csr_wdata;
               default:    mode_ff   <= mode_ff;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cnt0_ff      <= cnt0_in;
      cnt1_ff      <= cnt1_in;
      cnt2_ff      <= cnt2_in;
      step_ff      <= step_in;
      lvl_ff       <= lvl_in;
      cap_idx_ff   <= cap_idx_in;
      idx_x_ff     <= idx_x_in;
      idx_y_ff     <= idx_y_in;
      idx_z_ff     <= idx_z_in;
      t_x_ff       <= t_x_in;
      t_y_ff       <= t_y_in;
      t_z_ff       <= t_z_in;
      buf0_ff      <= buf0_in;
      buf1_ff      <= buf1_in;
      buf2_ff      <= buf2_in;
      d1_ff        <= d1_in;
      d2_ff        <= d2_in;
      d3_ff        <= d3_in;
      base_ff      <= base_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_field_value = rsp_value_ff;
   assign rsp_saturated   = rsp_sat_ff;

endmodule

`default_nettype wire
